>>> design/mepw_pkg.sv
package mepw_pkg;

  localparam int unsigned ENTRIES_DEF          = 10;
  localparam int unsigned HEARTBEAT_SECS_DEF   = 3;
  localparam int unsigned MAX_TIMEOUT_SECS_DEF = 120;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ID_W      = 22;
  localparam int unsigned SECS_W    = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned BSECS_W   = 18;
  // A timeout tripled for init needs two more bits than the requested value.
  localparam int unsigned SECS3_W   = 18;

  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;
  localparam logic [ID_W-1:0]    INIT_ID   = ID_W'(1);

  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_KICK    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_TIMEOUT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   pid;
    logic [SECS_W-1:0] timeout_secs;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                warn_any;
    logic                init_warned;
    logic                dump_request;
    logic                panic_request;
    logic                signal_init;
    logic [ID_W-1:0]     block_id;
    logic [BSECS_W-1:0]  block_secs;
  } res_t;

  // The phase field tracks ticks modulo limit, so no divider is needed per tick.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] ticks;
    logic [LIMIT_W-1:0] phase;
    logic [LIMIT_W-1:0] limit;
  } entry_t;

  typedef struct packed {
    logic warn;
    logic init_w;
    logic dump;
    logic panic;
  } flags_t;

endpackage

>>> design/mepw_table.sv
module mepw_table #(
  parameter int unsigned ENTRIES = mepw_pkg::ENTRIES_DEF,
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  mepw_pkg::entry_t    wdata_i,
  input  logic [IdxW-1:0]     raddr_i,
  output mepw_pkg::entry_t    rdata_o
);

  mepw_pkg::entry_t mem_q [ENTRIES];
  mepw_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mepw_div.sv
module mepw_div #(
  parameter int unsigned DIVISOR = mepw_pkg::HEARTBEAT_SECS_DEF,
  localparam int unsigned RemW = $clog2(DIVISOR + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mepw_pkg::SECS3_W-1:0] dividend_i,
  output logic                         done_o,
  output logic [mepw_pkg::SECS3_W-1:0] quot_o,
  output logic [RemW-1:0]              rem_o
);

  localparam int unsigned W    = mepw_pkg::SECS3_W;
  localparam int unsigned ShW  = W + $clog2(DIVISOR);
  localparam int unsigned RecW = W + 2;
  localparam int unsigned PW   = ShW + W;
  localparam longint unsigned RecVal =
    ((64'd1 << ShW) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RecW-1:0] RecC = RecW'(RecVal);
  localparam logic [W-1:0]    DivC = W'(DIVISOR);

  logic          s1_q;
  logic          s2_q;
  logic          done_q;
  logic [W-1:0]  num_q;
  logic [W-1:0]  quo_q;
  logic [RemW-1:0] rem_q;
  logic [PW-1:0] prod;
  logic [W-1:0]  back;
  logic [W-1:0]  diff;

  // The rounded-up reciprocal with this shift gives the exact quotient for
  // every dividend of W bits; the remainder is registered in the cycle after the quotient.
  assign prod = PW'(num_q) * PW'(RecC);
  assign back = quo_q * DivC;
  assign diff = num_q - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (s1_q) begin
      quo_q <= prod[ShW +: W];
    end
    if (s2_q) begin
      rem_q <= diff[RemW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> design/multi_entry_process_watchdog_unit.sv
// Timing: a tick or a disable/kick walks the table entry by entry before the strobe (a kick
// stops at its match); an enable waits for the divider to deliver quotient and remainder.
// Throughput: one word at a time; a new word is acted on only once busy has dropped.
// The result is held one cycle with res_valid_o high and cannot be stalled.
// Reset (rst_ni low, asynchronous) empties the table, clears the last dump record
// and clears test_mode; table contents stay undefined until written.
module multi_entry_process_watchdog_unit #(
  parameter int unsigned ENTRIES          = mepw_pkg::ENTRIES_DEF,
  parameter int unsigned HEARTBEAT_SECS   = mepw_pkg::HEARTBEAT_SECS_DEF,
  parameter int unsigned MAX_TIMEOUT_SECS = mepw_pkg::MAX_TIMEOUT_SECS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  mepw_pkg::item_t item_i,
  output logic            res_valid_o,
  output mepw_pkg::res_t  res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_data_i
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned RemW = $clog2(HEARTBEAT_SECS + 1);
  localparam int unsigned S3W  = mepw_pkg::SECS3_W;
  localparam int unsigned TW   = mepw_pkg::TICKS_W;
  localparam int unsigned LW   = mepw_pkg::LIMIT_W;
  localparam int unsigned BW   = mepw_pkg::BSECS_W;

  localparam logic [CntW-1:0] CntFull = CntW'(ENTRIES);
  localparam logic [S3W-1:0]  SecsMin = S3W'(HEARTBEAT_SECS);
  localparam logic [S3W-1:0]  SecsMax = S3W'(MAX_TIMEOUT_SECS);
  localparam logic [BW-1:0]   HbC     = BW'(HEARTBEAT_SECS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  mepw_pkg::item_t           item_q, item_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [CntW-1:0]           rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]           ex_idx_q, ex_idx_d;
  logic                      pending_q, pending_d;
  mepw_pkg::flags_t          acc_q, acc_d;
  logic [mepw_pkg::ID_W-1:0] last_id_q, last_id_d;
  logic [BW-1:0]             last_secs_q, last_secs_d;
  logic                      res_valid_q, res_valid_d;
  mepw_pkg::res_t            res_q, res_d;
  logic                      test_mode_q;

  logic                      mem_we;
  logic [IdxW-1:0]           mem_waddr;
  mepw_pkg::entry_t          mem_wdata;
  mepw_pkg::entry_t          rdata;

  logic                      div_start;
  logic                      div_done;
  logic [S3W-1:0]            div_quot;
  logic [RemW-1:0]           div_rem;

  logic [S3W-1:0]            secs_ext;
  logic [S3W-1:0]            secs3;
  logic                      secs_bad;

  logic                      issue;
  logic                      is_last;
  logic                      t_sat;
  logic [TW-1:0]             t_new;
  logic [LW:0]               phase_inc;
  logic [LW-1:0]             phase_new;
  logic                      e_warn;
  logic                      e_dump;
  logic                      e_init;
  logic [BW-1:0]             e_secs;
  mepw_pkg::entry_t          e_upd;

  mepw_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  mepw_div #(
    .DIVISOR (HEARTBEAT_SECS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (secs3),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  function automatic mepw_pkg::res_t tick_res(mepw_pkg::flags_t f,
                                              logic [mepw_pkg::ID_W-1:0] id,
                                              logic [BW-1:0] secs);
    mepw_pkg::res_t r;
    r.status        = mepw_pkg::ST_OK;
    r.warn_any      = f.warn;
    r.init_warned   = f.init_w;
    r.dump_request  = f.dump;
    r.panic_request = f.panic;
    r.signal_init   = f.init_w & f.dump;
    r.block_id      = id;
    r.block_secs    = secs;
    return r;
  endfunction

  function automatic mepw_pkg::res_t status_res(logic [mepw_pkg::STATUS_W-1:0] st);
    mepw_pkg::res_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  // Timeout check for enable, taken straight from the incoming word.
  assign secs_ext = S3W'(item_i.timeout_secs);
  assign secs3    = (test_mode_q && (item_i.pid == mepw_pkg::INIT_ID)) ?
                    (secs_ext + (secs_ext << 1)) : secs_ext;
  assign secs_bad = (secs3 > SecsMax) || (secs3 < SecsMin);

  // Per-entry tick unit, shared over all entries as they stream out of the table.
  assign t_sat     = rdata.ticks == mepw_pkg::TICKS_MAX;
  assign t_new     = t_sat ? rdata.ticks : (rdata.ticks + TW'(1));
  assign phase_inc = {1'b0, rdata.phase} + (LW + 1)'(1);
  assign phase_new = t_sat ? rdata.phase :
                     ((phase_inc == {1'b0, rdata.limit}) ? '0 : phase_inc[LW-1:0]);
  assign e_warn    = (t_new >= TW'(rdata.limit)) || (t_new == TW'(rdata.limit >> 1));
  assign e_dump    = (rdata.limit != '0) && (phase_new == '0);
  assign e_init    = rdata.id == mepw_pkg::INIT_ID;
  assign e_secs    = BW'(t_new) * HbC;

  always_comb begin
    e_upd       = rdata;
    e_upd.ticks = t_new;
    e_upd.phase = phase_new;
  end

  assign issue   = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rd_idx_q < count_q);
  assign is_last = pending_q && ((CntW'(ex_idx_q) + CntW'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    count_d     = count_q;
    rd_idx_d    = issue ? (rd_idx_q + CntW'(1)) : rd_idx_q;
    ex_idx_d    = issue ? rd_idx_q[IdxW-1:0] : ex_idx_q;
    acc_d       = acc_q;
    last_id_d   = last_id_q;
    last_secs_d = last_secs_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = ex_idx_q;
    mem_wdata   = e_upd;
    div_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d = item_i;
          unique case (item_i.cmd)
            mepw_pkg::CMD_TICK: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = tick_res('0, last_id_q, last_secs_q);
              end else begin
                state_d  = S_SCAN;
                rd_idx_d = '0;
                acc_d    = '0;
              end
            end
            mepw_pkg::CMD_ENABLE: begin
              if (secs_bad) begin
                res_valid_d = 1'b1;
                res_d       = status_res(mepw_pkg::ST_BAD_TIMEOUT);
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            mepw_pkg::CMD_DISABLE, mepw_pkg::CMD_KICK: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                res_d       = status_res(mepw_pkg::ST_NOT_FOUND);
              end else begin
                state_d  = S_SCAN;
                rd_idx_d = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          if (div_rem != '0) begin
            res_d = status_res(mepw_pkg::ST_BAD_TIMEOUT);
          end else if (count_q >= CntFull) begin
            res_d = status_res(mepw_pkg::ST_FULL);
          end else begin
            mem_we          = 1'b1;
            mem_waddr       = count_q[IdxW-1:0];
            mem_wdata.id    = item_q.pid;
            mem_wdata.ticks = '0;
            mem_wdata.phase = '0;
            mem_wdata.limit = div_quot[LW-1:0];
            count_d         = count_q + CntW'(1);
            res_d           = status_res(mepw_pkg::ST_OK);
          end
        end
      end

      S_SCAN: begin
        if (pending_q) begin
          if (item_q.cmd == mepw_pkg::CMD_TICK) begin
            mem_we = 1'b1;
            if (e_warn) begin
              acc_d.warn = 1'b1;
              if (e_init) begin
                acc_d.init_w = 1'b1;
              end
            end
            if (e_dump) begin
              acc_d.dump  = 1'b1;
              last_id_d   = rdata.id;
              last_secs_d = e_secs;
              if (!e_init || test_mode_q) begin
                acc_d.panic = 1'b1;
              end
            end
            if (is_last) begin
              state_d     = S_IDLE;
              res_valid_d = 1'b1;
              res_d       = tick_res(acc_d, last_id_d, last_secs_d);
            end
          end else if (rdata.id == item_q.pid) begin
            if (item_q.cmd == mepw_pkg::CMD_KICK) begin
              mem_we          = 1'b1;
              mem_wdata       = rdata;
              mem_wdata.ticks = '0;
              mem_wdata.phase = '0;
              state_d         = S_IDLE;
              res_valid_d     = 1'b1;
              res_d           = status_res(mepw_pkg::ST_OK);
            end else if (is_last) begin
              count_d     = count_q - CntW'(1);
              state_d     = S_IDLE;
              res_valid_d = 1'b1;
              res_d       = status_res(mepw_pkg::ST_OK);
            end else begin
              // The entry after the match is already being read; move it down next.
              state_d = S_SHIFT;
            end
          end else if (is_last) begin
            state_d     = S_IDLE;
            res_valid_d = 1'b1;
            res_d       = status_res(mepw_pkg::ST_NOT_FOUND);
          end
        end
      end

      S_SHIFT: begin
        if (pending_q) begin
          mem_we    = 1'b1;
          mem_waddr = ex_idx_q - IdxW'(1);
          mem_wdata = rdata;
          if (is_last) begin
            count_d     = count_q - CntW'(1);
            state_d     = S_IDLE;
            res_valid_d = 1'b1;
            res_d       = status_res(mepw_pkg::ST_OK);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    pending_d = issue && (state_d != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      pending_q   <= 1'b0;
      acc_q       <= '0;
      last_id_q   <= '0;
      last_secs_q <= '0;
      res_valid_q <= 1'b0;
      test_mode_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      pending_q   <= pending_d;
      acc_q       <= acc_d;
      last_id_q   <= last_id_d;
      last_secs_q <= last_secs_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        test_mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    ex_idx_q <= ex_idx_d;
    res_q    <= res_d;
  end

  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> design/mepw_checker.sv
module mepw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_i,
  input logic           res_valid_i,
  input mepw_pkg::res_t res_i
);

  // A word is reported only once the block has gone back to idle.
  a_res_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !busy_i)
    else $error("result strobe while busy");

  // Leaving the busy state always delivers the word's result at the same time.
  a_fall_gives_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> res_valid_i)
    else $error("busy dropped without a result");

  // The block only becomes busy after accepting a word.
  a_rise_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_i) |-> $past(start_i))
    else $error("busy rose without start");

  a_signal_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_i.signal_init) |-> (res_i.init_warned && res_i.dump_request))
    else $error("signal_init without init warning and dump");

  a_panic_needs_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_i.panic_request) |-> res_i.dump_request)
    else $error("panic request without dump request");

endmodule

bind multi_entry_process_watchdog_unit mepw_checker u_mepw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .res_valid_i (res_valid_o),
  .res_i       (res_o)
);
